// File: rtl/assert_macros.svh
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk, off while arst_n is low.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Concurrent check that an expression never holds.
`define ASSERT_NEVER(label, expr, msg) \
	`ASSERT_CLK(label, !(expr), msg)

`endif

// File: rtl/buis_pkg.sv
// Types and constants of the bounded uniform integer sampler.
`timescale 1ns / 1ps
`default_nettype none

package buis_pkg;

	localparam int WORD_W = 32;
	localparam int CFG_IDX_W = 2;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	// Register indexes of the configuration port.
	localparam cfg_idx_t REG_RANGE_LOW = 2'd0;
	localparam cfg_idx_t REG_RANGE_HIGH = 2'd1;

	// Threshold division: one quotient bit per cycle.
	localparam int DIV_CNT_W = 6;
	localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 6'd32;

endpackage

`default_nettype wire

// File: rtl/bounded_uniform_int_sampler_core.sv
// Bounded uniform integer sampler: random words to integers in [low, high].
//
//  channel   signals                                 dir   accepted when
//  input     in_valid, in_stall, random_word         in    in_valid && !in_stall
//  output    out_valid, out_stall, sample_value,     out   out_valid && !out_stall
//            range_error
//  config    cfg_we, cfg_index, cfg_data             in    cfg_we
//
// One word per cycle unless in_stall holds the input; a word runs through the
// input register, product register and result register.
// A range write starts a threshold division (one remainder bit a cycle);
// in_stall stays high until it ends. Reset leaves the range [0, 0].
// A stalled result holds in the result register while the stages behind it
// keep filling; rejected words are dropped at the product stage.
`timescale 1ns / 1ps
`default_nettype none

module bounded_uniform_int_sampler_core
	import buis_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire cfg_idx_t          cfg_index,
	input  wire word_t             cfg_data,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire word_t             random_word,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic signed [WORD_W-1:0] sample_value,
	output logic                   range_error
);

	word_t range_low_q;
	word_t range_high_q;
	word_t span_minus_one_q;
	word_t span_q;
	word_t reject_threshold_q;

	logic                 pend_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	word_t                div_d_q;
	word_t                div_r_q;
	logic [WORD_W:0]      div_shift;
	logic [WORD_W:0]      div_diff;
	word_t                div_r_next;
	word_t                span_next_m1;
	logic                 busy;

	logic            valid_s1;
	word_t           word_s1;
	logic            valid_s2;
	word_t           word_s2;
	logic [2*WORD_W-1:0] prod_s2;

	logic  out_valid_q;
	word_t sample_q;
	logic  error_q;

	logic inverted;
	logic full_span;
	logic keep_s2;
	logic out_adv;
	logic s2_adv;
	logic s1_adv;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_low_q <= '0;
			range_high_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RANGE_LOW:  range_low_q <= cfg_data;
				REG_RANGE_HIGH: range_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Threshold (2^32 - s) mod s by restoring division.
	assign span_next_m1 = range_high_q - range_low_q;
	assign div_shift = {div_r_q, div_d_q[WORD_W-1]};
	assign div_diff = div_shift - {1'b0, span_q};
	assign div_r_next = div_diff[WORD_W] ? div_shift[WORD_W-1:0] : div_diff[WORD_W-1:0];
	assign busy = pend_q || (div_cnt_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			div_cnt_q <= '0;
			span_minus_one_q <= '0;
			span_q <= word_t'(1);
			reject_threshold_q <= '0;
		end else begin
			if (cfg_we && (cfg_index == REG_RANGE_LOW || cfg_index == REG_RANGE_HIGH)) begin
				pend_q <= 1'b1;
			end else if (pend_q) begin
				pend_q <= 1'b0;
			end
			if (pend_q) begin
				span_minus_one_q <= span_next_m1;
				span_q <= span_next_m1 + word_t'(1);
				div_cnt_q <= DIV_STEPS;
			end else if (div_cnt_q != '0) begin
				div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
				if (div_cnt_q == DIV_CNT_W'(1)) begin
					reject_threshold_q <= (span_q == '0) ? '0 : div_r_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pend_q) begin
			div_d_q <= '0 - (span_next_m1 + word_t'(1));
			div_r_q <= '0;
		end else if (div_cnt_q != '0) begin
			div_d_q <= {div_d_q[WORD_W-2:0], 1'b0};
			div_r_q <= div_r_next;
		end
	end

	// Range modes; the user must keep them steady while words are in flight, which the core does not enforce.
	assign inverted = $signed(range_low_q) > $signed(range_high_q);
	assign full_span = (span_minus_one_q == '1);
	assign keep_s2 = inverted || full_span || (prod_s2[WORD_W-1:0] >= reject_threshold_q);

	assign out_adv = !out_valid_q || !out_stall;
	assign s2_adv = !valid_s2 || !keep_s2 || out_adv;
	assign s1_adv = !valid_s1 || s2_adv;
	assign in_stall = busy || !s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_adv) begin
				valid_s1 <= in_valid && !busy;
			end
			if (s2_adv) begin
				valid_s2 <= valid_s1;
			end
			if (out_adv) begin
				out_valid_q <= valid_s2 && keep_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			word_s1 <= random_word;
		end
		if (s2_adv) begin
			word_s2 <= word_s1;
			prod_s2 <= {{WORD_W{1'b0}}, word_s1} * {{WORD_W{1'b0}}, span_q};
		end
		if (out_adv && valid_s2 && keep_s2) begin
			if (inverted) begin
				sample_q <= range_low_q;
				error_q <= 1'b1;
			end else if (full_span) begin
				sample_q <= range_low_q + word_s2;
				error_q <= 1'b0;
			end else begin
				sample_q <= range_low_q + prod_s2[2*WORD_W-1:WORD_W];
				error_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign sample_value = $signed(sample_q);
	assign range_error = error_q;

endmodule

`default_nettype wire

// File: rtl/buis_checker.sv
// Port-level checks of the sampler core, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module buis_checker
	import buis_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              cfg_we,
	input wire cfg_idx_t          cfg_index,
	input wire word_t             cfg_data,
	input wire logic              in_valid,
	input wire logic              in_stall,
	input wire word_t             random_word,
	input wire logic              out_valid,
	input wire logic              out_stall,
	input wire logic signed [WORD_W-1:0] sample_value,
	input wire logic              range_error
);

	logic            cfg_range_we;
	logic            out_hold;
	logic [WORD_W:0] out_word;

	// writes to unused indexes leave the threshold alone
	assign cfg_range_we = cfg_we && (cfg_index == REG_RANGE_LOW || cfg_index == REG_RANGE_HIGH);
	assign out_hold = out_valid && out_stall;
	assign out_word = {sample_value, range_error};

	// hold a stalled result word
	`ASSERT_CLK(a_out_hold, out_hold |=> out_valid && $stable(out_word), "stalled word changed")

	`ASSERT_CLK(a_out_drop, $fell(out_valid) |-> $past(!out_stall), "result word dropped while stalled")

	// a range write must close the input until the threshold is ready
	`ASSERT_CLK(a_cfg_stall_start, cfg_range_we |=> in_stall, "input open right after a range write")

	`ASSERT_CLK(a_cfg_stall_late, cfg_range_we |-> ##33 in_stall, "input open before threshold ready")

endmodule

bind bounded_uniform_int_sampler_core buis_checker u_buis_checker (.*);

`default_nettype wire

// File: bench/tb.sv
// Self-checking bench for the bounded uniform integer sampler: range settings, words, samples.
`timescale 1ns / 1ps

module tb;
	import buis_pkg::*;

	localparam cfg_idx_t REG_SPARE_A = 2'd2;
	localparam cfg_idx_t REG_SPARE_B = 2'd3;
	localparam int RANDOM_PHASES = 14;
	localparam int WORDS_PER_PHASE = 60;
	localparam int HOLD_PHASE = 3;
	localparam int STEADY_PHASE = 5;
	localparam int LONG_HOLD = 300;
	localparam int DRAIN_CYCLES = 10;
	localparam int MAX_REPORTS = 10;

	typedef enum {STALL_NONE, STALL_RANDOM, STALL_PERIODIC} stall_kind_t;

	typedef struct packed {
		word_t value;
		logic  flagged;
	} sample_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	cfg_idx_t cfg_index = REG_RANGE_LOW;
	word_t cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	word_t random_word = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [WORD_W-1:0] sample_value;
	logic range_error;

	// copy of the range registers and what follows from them
	word_t cur_low, cur_high, cur_span_m1, cur_cutoff;

	word_t words_to_send[$];
	sample_t pending_samples[$];

	int gap_max = 0;
	stall_kind_t stall_mode = STALL_NONE;
	int stall_pct = 0;
	int hold_requests = 0;

	int burst_left, gap_left, hold_left, hold_served, stall_tick;
	logic next_valid, pred_flag;
	word_t next_word, pred_value;
	sample_t oldest;

	int mismatches = 0;
	int words_taken = 0;
	int words_dropped = 0;
	int samples_checked = 0;
	int samples_flagged = 0;
	int range_writes = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	bounded_uniform_int_sampler_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.random_word  (random_word),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.sample_value (sample_value),
		.range_error  (range_error)
	);

	function automatic void refresh_cutoff();
		word_t span;
		cur_span_m1 = cur_high - cur_low;
		span = cur_span_m1 + 32'd1;
		cur_cutoff = (span == '0) ? '0 : (word_t'(0) - span) % span;
	endfunction

	// Returns 1 when the word yields a sample, 0 when it is dropped.
	function automatic logic sample_for_word(input word_t w, output word_t val,
			output logic flag);
		logic [63:0] prod;
		word_t span;
		val = cur_low;
		flag = 1'b0;
		if ($signed(cur_low) > $signed(cur_high)) begin
			flag = 1'b1;
			return 1'b1;
		end
		if (cur_span_m1 == '1) begin
			val = cur_low + w;
			return 1'b1;
		end
		span = cur_span_m1 + 32'd1;
		prod = {32'd0, w} * {32'd0, span};
		if (prod[31:0] < cur_cutoff)
			return 1'b0;
		val = cur_low + prod[63:32];
		return 1'b1;
	endfunction

	function automatic word_t range_edge(input int k);
		case (k)
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0000_0000;
			default: return 32'hFFFF_FFFF;
		endcase
	endfunction

	task automatic note_mismatch(input string what, input sample_t want, input word_t got_v,
			input logic got_e);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%0t %s: expected value %h error %b, got value %h error %b",
				$time, what, want.value, want.flagged, got_v, got_e);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input word_t data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_RANGE_LOW: cur_low = data;
			REG_RANGE_HIGH: cur_high = data;
			default: ;
		endcase
		if (idx == REG_RANGE_LOW || idx == REG_RANGE_HIGH)
			refresh_cutoff();
		range_writes++;
		@(negedge clk);
	endtask

	// Rejected words leave nothing behind, so give the pipeline time to empty.
	task automatic wait_idle();
		while (words_to_send.size() != 0 || in_valid || pending_samples.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Sender: bursts of words separated by random gaps while gap_max is nonzero.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			random_word <= '0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			next_valid = in_valid;
			next_word = random_word;
			if (in_valid && !in_stall) begin
				words_taken++;
				if (sample_for_word(random_word, pred_value, pred_flag))
					pending_samples.push_back('{value: pred_value, flagged: pred_flag});
				else
					words_dropped++;
				next_valid = 1'b0;
			end
			if (!next_valid) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (words_to_send.size() != 0) begin
					next_valid = 1'b1;
					next_word = words_to_send.pop_front();
					if (burst_left > 0)
						burst_left--;
					if (burst_left == 0 && gap_max > 0) begin
						burst_left = $urandom_range(1, 12);
						gap_left = $urandom_range(1, gap_max);
					end
				end
			end
			in_valid <= next_valid;
			random_word <= next_word;
		end
	end

	// Receiver: stall pattern, plus a long hold whenever one is requested.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left = 0;
			hold_served = 0;
			stall_tick = 0;
		end else begin
			stall_tick++;
			if (hold_left == 0 && hold_served != hold_requests) begin
				hold_left = LONG_HOLD;
				hold_served++;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				case (stall_mode)
					STALL_NONE: out_stall <= 1'b0;
					STALL_RANDOM: out_stall <= ($urandom_range(0, 99) < stall_pct);
					default: out_stall <= ((stall_tick % 7) < 3);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_samples.size() == 0) begin
				note_mismatch("unexpected sample", '0, sample_value, range_error);
			end else begin
				oldest = pending_samples.pop_front();
				if (sample_value !== oldest.value || range_error !== oldest.flagged)
					note_mismatch("sample mismatch", oldest, sample_value, range_error);
				else begin
					samples_checked++;
					if (oldest.flagged)
						samples_flagged++;
				end
			end
		end
	end

	initial begin
		word_t lo_pick, hi_pick;
		cur_low = '0;
		cur_high = '0;
		refresh_cutoff();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// range after reset is [0, 0]: every word gives 0
		words_to_send.push_back(32'h0000_0000);
		words_to_send.push_back(32'hFFFF_FFFF);
		words_to_send.push_back(32'h1234_5678);
		wait_idle();

		// whole signed range: sample is the low bound plus the word
		write_reg(REG_RANGE_LOW, 32'h8000_0000);
		write_reg(REG_RANGE_HIGH, 32'h7FFF_FFFF);
		words_to_send.push_back(32'h0000_0000);
		words_to_send.push_back(32'hFFFF_FFFF);
		words_to_send.push_back(32'h8000_0000);
		words_to_send.push_back(32'h7FFF_FFFF);
		words_to_send.push_back(32'h5555_5555);
		words_to_send.push_back(32'hAAAA_AAAA);
		wait_idle();

		// span of three, word zero falls below the cutoff
		write_reg(REG_RANGE_LOW, 32'hFFFF_FFFF);
		write_reg(REG_RANGE_HIGH, 32'h0000_0001);
		words_to_send.push_back(32'h0000_0000);
		words_to_send.push_back(32'h0000_0001);
		words_to_send.push_back(32'hFFFF_FFFF);
		words_to_send.push_back(32'h5555_5556);
		wait_idle();

		// span just over half the word space: heavy rejection
		write_reg(REG_RANGE_LOW, 32'h8000_0000);
		write_reg(REG_RANGE_HIGH, 32'h0000_0000);
		words_to_send.push_back(32'h0000_0000);
		words_to_send.push_back(32'h0000_0001);
		words_to_send.push_back(32'h8000_0000);
		words_to_send.push_back(32'hFFFF_FFFF);
		wait_idle();

		// inverted range, then writes to unused indexes that must change nothing
		write_reg(REG_RANGE_LOW, 32'd5);
		write_reg(REG_RANGE_HIGH, -32'sd5);
		words_to_send.push_back(32'h0000_0000);
		words_to_send.push_back(32'hFFFF_FFFF);
		wait_idle();
		write_reg(REG_SPARE_A, $urandom);
		write_reg(REG_SPARE_B, $urandom);
		words_to_send.push_back(32'h0000_0001);
		wait_idle();

		// single value at the top of the range
		write_reg(REG_RANGE_LOW, 32'h7FFF_FFFF);
		write_reg(REG_RANGE_HIGH, 32'h7FFF_FFFF);
		words_to_send.push_back(32'h0000_0000);
		words_to_send.push_back(32'hFFFF_FFFF);
		wait_idle();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case ($urandom_range(0, 5))
				0: begin
					lo_pick = $urandom;
					hi_pick = lo_pick + $urandom_range(0, 15);
				end
				1: begin
					lo_pick = $urandom;
					hi_pick = $urandom;
				end
				2: begin
					lo_pick = range_edge($urandom_range(0, 3));
					hi_pick = range_edge($urandom_range(0, 3));
				end
				3: begin
					lo_pick = $urandom;
					hi_pick = lo_pick + 32'h8000_0000 + $urandom_range(0, 255);
				end
				4: begin
					lo_pick = $urandom;
					hi_pick = lo_pick + $urandom_range(0, 1000);
				end
				default: begin
					lo_pick = $urandom;
					hi_pick = lo_pick - 32'd1;
				end
			endcase
			if ($urandom_range(0, 3) != 0)
				write_reg(REG_RANGE_LOW, lo_pick);
			write_reg(REG_RANGE_HIGH, hi_pick);
			if ($urandom_range(0, 4) == 0)
				write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, $urandom);

			if (p == HOLD_PHASE || p == STEADY_PHASE) begin
				gap_max = 0;
				stall_mode = STALL_NONE;
				if (p == HOLD_PHASE)
					hold_requests++;
			end else begin
				case ($urandom_range(0, 3))
					0: gap_max = 0;
					1: gap_max = 2;
					2: gap_max = 6;
					default: gap_max = 20;
				endcase
				stall_mode = stall_kind_t'($urandom_range(0, 2));
				stall_pct = $urandom_range(10, 70);
			end

			for (int i = 0; i < WORDS_PER_PHASE; i++) begin
				if ($urandom_range(0, 9) == 0)
					words_to_send.push_back(range_edge($urandom_range(0, 3)));
				else
					words_to_send.push_back($urandom);
			end
			wait_idle();
		end

		$display("run covered %0d words under %0d register writes, %0d dropped by rejection",
			words_taken, range_writes, words_dropped);
		$display("%0d samples checked, %0d of them flagged as inverted range",
			samples_checked, samples_flagged);
		if (mismatches == 0 && pending_samples.size() == 0)
			$display("[bounded_uniform_int_sampler_core] OK");
		else
			$display("[bounded_uniform_int_sampler_core] ERROR");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("timeout with %0d samples outstanding", pending_samples.size());
		$display("[bounded_uniform_int_sampler_core] ERROR");
		$finish;
	end

endmodule

// File: files.f
+incdir+rtl
rtl/buis_pkg.sv
rtl/bounded_uniform_int_sampler_core.sv
rtl/buis_checker.sv
bench/tb.sv
